// ===== hdl/sfd_pkg.sv =====
// Shared types and constants for the 6to4 decapsulation address filter.
package sfd_pkg;

  // Transaction payloads
  typedef struct packed {
    logic [3:0]  ip_version;
    logic [7:0]  next_proto;
    logic [31:0] outer_src;
    logic [31:0] outer_dst;
    logic [63:0] inner_src_hi;
    logic [63:0] inner_src_lo;
    logic [63:0] inner_dst_hi;
    logic [63:0] inner_dst_lo;
  } sfd_in_t;

  typedef struct packed {
    logic       accept;
    logic [3:0] verdict;
  } sfd_out_t;

  // Configuration register contents
  typedef struct packed {
    logic        iface_enabled;
    logic        decap_disabled;
    logic        local_valid;
    logic [31:0] local_v4_addr;
    logic [31:0] local_prefix_mask;
  } sfd_cfg_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_IFACE_ENABLED     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DECAP_DISABLED    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOCAL_VALID       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LOCAL_V4_ADDR     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LOCAL_PREFIX_MASK = 3'd4;

  // Verdict codes, first failing check wins
  localparam logic [3:0] VERD_OK          = 4'd0;
  localparam logic [3:0] VERD_DOWN        = 4'd1;
  localparam logic [3:0] VERD_NODECAP     = 4'd2;
  localparam logic [3:0] VERD_PROTO       = 4'd3;
  localparam logic [3:0] VERD_VERSION     = 4'd4;
  localparam logic [3:0] VERD_NOLOCAL     = 4'd5;
  localparam logic [3:0] VERD_DSTMISMATCH = 4'd6;
  localparam logic [3:0] VERD_SRCPREFIX   = 4'd7;
  localparam logic [3:0] VERD_ODST        = 4'd8;
  localparam logic [3:0] VERD_OSRC        = 4'd9;
  localparam logic [3:0] VERD_IDST        = 4'd10;
  localparam logic [3:0] VERD_ISRC        = 4'd11;

  localparam logic [7:0] PROTO_IPV6   = 8'd41;
  localparam logic [3:0] IP_VERSION_4 = 4'd4;

  // IPv4 bogon prefixes
  localparam logic [3:0]  V4_MCAST_NIBBLE = 4'he;
  localparam logic [7:0]  V4_NET_ZERO     = 8'd0;
  localparam logic [7:0]  V4_NET_LOOP     = 8'd127;
  localparam logic [7:0]  V4_NET_BCAST    = 8'd255;
  localparam logic [7:0]  V4_NET_TEN      = 8'd10;
  localparam logic [11:0] V4_PFX_172_16   = 12'hac1;
  localparam logic [15:0] V4_PFX_192_168  = 16'hc0a8;
  localparam logic [7:0]  V4_LL_BYTE0     = 8'd169;
  localparam logic [7:0]  V4_LL_BYTE1     = 8'd254;

  // IPv6 prefixes
  localparam logic [15:0] V6_PFX_6TO4     = 16'h2002;
  localparam logic [31:0] V6_MAPPED_WORD  = 32'h0000ffff;
  localparam logic [9:0]  V6_PFX_LINKLOC  = 10'h3fa;
  localparam logic [9:0]  V6_PFX_SITELOC  = 10'h3fb;
  localparam logic [7:0]  V6_MCAST_BYTE   = 8'hff;
  localparam logic [3:0]  V6_SCOPE_NODE   = 4'd1;
  localparam logic [3:0]  V6_SCOPE_LINK   = 4'd2;

endpackage

// ===== hdl/sixtofour_decap_address_filter.sv =====
// Top level of the 6to4 decapsulation address filter: config, pipeline, checks.
// Each transaction passes the input register, then the result register, before out_valid.
// Throughput: one transaction per cycle while out_stall is low, through the single classify stage.
// Output stall backs up into the input register; in_stall rises only when both hold data.
// Reset (rst_n low, synchronous): pipeline emptied, all config registers cleared to 0.
// Config is sampled live by the classifier; write it only while the block is idle.
module sixtofour_decap_address_filter
  import sfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  sfd_in_t             in_data,

  output logic                out_valid,
  input  logic                out_stall,
  output sfd_out_t            out_data,

  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  // Configuration registers
  sfd_cfg_t cfg_r;
  sfd_cfg_t cfg_nxt;

  // Input register stage
  logic    s1_valid_r;
  sfd_in_t s1_data_r;

  // Result register stage
  logic     out_valid_r;
  sfd_out_t out_data_r;

  sfd_out_t cls_res;
  logic     out_free;
  logic     s1_adv;
  logic     in_take;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IFACE_ENABLED:     cfg_nxt.iface_enabled     = cfg_wdata[0];
        CFG_DECAP_DISABLED:    cfg_nxt.decap_disabled    = cfg_wdata[0];
        CFG_LOCAL_VALID:       cfg_nxt.local_valid       = cfg_wdata[0];
        CFG_LOCAL_V4_ADDR:     cfg_nxt.local_v4_addr     = cfg_wdata;
        CFG_LOCAL_PREFIX_MASK: cfg_nxt.local_prefix_mask = cfg_wdata;
        default:               cfg_nxt = cfg_r;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Handshake: result slot frees when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  sfd_classify u_classify (
    .hdr (s1_data_r),
    .cfg (cfg_r),
    .res (cls_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= cls_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // accept flag must agree with the verdict code
  a_accept_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.accept == (out_data_r.verdict == VERD_OK)))
    else $error("accept flag disagrees with verdict");

  // verdict stays within the defined codes
  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.verdict <= VERD_ISRC))
    else $error("verdict code out of range");

  // empty input register never back-pressures
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("stall raised with empty input register");

  // a held transaction moves on when the result slot is empty
  a_advance_to_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("transaction lost between stages");

  // a stalled result keeps its value
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");

endmodule

// ===== hdl/sfd_v4_bogon.sv =====
// IPv4 bogon address check: multicast, 0/8, 127/8, 255/8, private and link-local.
module sfd_v4_bogon
  import sfd_pkg::*;
(
  input  logic [31:0] addr,
  output logic        bad
);

  logic [7:0] top;

  assign top = addr[31:24];

  assign bad = (addr[31:28] == V4_MCAST_NIBBLE)
            || (top == V4_NET_ZERO) || (top == V4_NET_LOOP) || (top == V4_NET_BCAST)
            || (top == V4_NET_TEN)
            || (addr[31:20] == V4_PFX_172_16)
            || (addr[31:16] == V4_PFX_192_168)
            || ((top == V4_LL_BYTE0) && (addr[23:16] == V4_LL_BYTE1));

endmodule

// ===== hdl/sfd_v6_check.sv =====
// IPv6 inner address check; 6to4 addresses fall back to the IPv4 bogon check.
module sfd_v6_check
  import sfd_pkg::*;
(
  input  logic [63:0] hi,
  input  logic [63:0] lo,
  output logic        bad
);

  logic v4_bad;
  logic hi_zero;
  logic compat;
  logic mapped;
  logic scoped_ll;
  logic mcast_local;

  sfd_v4_bogon u_v4 (
    .addr (hi[47:16]),
    .bad  (v4_bad)
  );

  assign hi_zero     = (hi == 64'd0);
  // v4-compatible: last word above 1 (skips :: and ::1)
  assign compat      = hi_zero && (lo[63:32] == 32'd0) && (|lo[31:1]);
  assign mapped      = hi_zero && (lo[63:32] == V6_MAPPED_WORD);
  assign scoped_ll   = (hi[63:54] == V6_PFX_LINKLOC) || (hi[63:54] == V6_PFX_SITELOC);
  assign mcast_local = (hi[63:56] == V6_MCAST_BYTE)
                    && ((hi[51:48] == V6_SCOPE_NODE) || (hi[51:48] == V6_SCOPE_LINK));

  assign bad = (hi[63:48] == V6_PFX_6TO4) ? v4_bad
             : (compat || mapped || scoped_ll || mcast_local);

endmodule

// ===== hdl/sfd_classify.sv =====
// Priority classifier that picks the first failing check for one header.
module sfd_classify
  import sfd_pkg::*;
(
  input  sfd_in_t  hdr,
  input  sfd_cfg_t cfg,
  output sfd_out_t res
);

  logic odst_bad;
  logic osrc_bad;
  logic idst_bad;
  logic isrc_bad;
  logic [3:0] verdict;

  sfd_v4_bogon u_odst (.addr(hdr.outer_dst), .bad(odst_bad));
  sfd_v4_bogon u_osrc (.addr(hdr.outer_src), .bad(osrc_bad));

  sfd_v6_check u_idst (.hi(hdr.inner_dst_hi), .lo(hdr.inner_dst_lo), .bad(idst_bad));
  sfd_v6_check u_isrc (.hi(hdr.inner_src_hi), .lo(hdr.inner_src_lo), .bad(isrc_bad));

  always_comb begin
    if (!cfg.iface_enabled) begin
      verdict = VERD_DOWN;
    end else if (cfg.decap_disabled) begin
      verdict = VERD_NODECAP;
    end else if (hdr.next_proto != PROTO_IPV6) begin
      verdict = VERD_PROTO;
    end else if (hdr.ip_version != IP_VERSION_4) begin
      verdict = VERD_VERSION;
    end else if (!cfg.local_valid) begin
      verdict = VERD_NOLOCAL;
    end else if (hdr.outer_dst != cfg.local_v4_addr) begin
      verdict = VERD_DSTMISMATCH;
    end else if ((hdr.outer_src & cfg.local_prefix_mask)
                 != (cfg.local_v4_addr & cfg.local_prefix_mask)) begin
      verdict = VERD_SRCPREFIX;
    end else if (odst_bad) begin
      verdict = VERD_ODST;
    end else if (osrc_bad) begin
      verdict = VERD_OSRC;
    end else if (idst_bad) begin
      verdict = VERD_IDST;
    end else if (isrc_bad) begin
      verdict = VERD_ISRC;
    end else begin
      verdict = VERD_OK;
    end
  end

  assign res.verdict = verdict;
  assign res.accept  = (verdict == VERD_OK);

endmodule
